// File: rtl/axrot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package axrot_pkg;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   localparam int PHASE_W   = 16;
   localparam int X_W       = 14;
   localparam int XC_W      = 15;
   localparam int T_W       = 31;
   localparam int SN_W      = 32;
   localparam int TRIG_W    = 17;
   localparam int FRAC_BITS = 15;

   localparam logic [XC_W-1:0]  QUARTER    = 15'd16384;
   localparam logic [SN_W-1:0]  SINE_HALF  = 32'd16384;
   localparam logic [TRIG_W-1:0] SINE_ONE  = 17'd32768;
   localparam int               ROUND_HALF = 16384;

   // Taylor coefficients of sin(pi/2 * t), unsigned Q30
   localparam logic [T_W-1:0] C1 = 31'd1686629713;
   localparam logic [T_W-1:0] C3 = 31'd693598668;
   localparam logic [T_W-1:0] C5 = 31'd85569306;
   localparam logic [T_W-1:0] C7 = 31'd5026995;
   localparam logic [T_W-1:0] C9 = 31'd172272;

   // Q30 x Q30 product truncated back to Q30; operands stay below 2^31
   function automatic logic [T_W-1:0] mul_q30(input logic [T_W-1:0] a,
                                              input logic [T_W-1:0] b);
      logic [2*T_W-1:0] prod;
      prod = (2*T_W)'(a) * (2*T_W)'(b);
      return prod[2*T_W-2:30];
   endfunction

endpackage

`default_nettype wire

// File: rtl/axis_rotation_row_transform_top.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted request enters the stage 0 register; rsp_valid is the valid bit of the last stage.
// Throughput: one transaction per cycle while rsp_stall is low; the quarter-wave sine is a
// pipeline of six Q30 multiplier stages followed by select, product and
// round/saturate stages, each behind its own register.
// Reset clears all stage valid bits; payload registers are not reset.
module axis_rotation_row_transform_top #(
   parameter int ANGLE_BITS = 16,
   parameter int ELEM_BITS  = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [ELEM_BITS-1:0] req_elem0,
   input  wire logic signed [ELEM_BITS-1:0] req_elem1,
   input  wire logic signed [ELEM_BITS-1:0] req_elem2,
   input  wire logic signed [ELEM_BITS-1:0] req_elem3,
   input  wire logic [1:0]                  req_axis,
   input  wire logic [ANGLE_BITS-1:0]       req_angle,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [ELEM_BITS-1:0]      rsp_res0,
   output logic signed [ELEM_BITS-1:0]      rsp_res1,
   output logic signed [ELEM_BITS-1:0]      rsp_res2,
   output logic signed [ELEM_BITS-1:0]      rsp_res3
);

   localparam int LAST   = 9;
   localparam int PROD_W = ELEM_BITS + axrot_pkg::TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int Q_W    = SUM_W - axrot_pkg::FRAC_BITS;
   localparam int T_W    = axrot_pkg::T_W;

   function automatic logic signed [ELEM_BITS-1:0] round_sat(
      input logic signed [SUM_W-1:0] a);
      logic signed [SUM_W-1:0] b;
      logic signed [Q_W-1:0]   q;
      b = a + SUM_W'(axrot_pkg::ROUND_HALF);
      q = Q_W'(b >>> axrot_pkg::FRAC_BITS);
      if (!q[Q_W-1] && (|q[Q_W-2:ELEM_BITS-1])) begin
         return {1'b0, {(ELEM_BITS-1){1'b1}}};
      end else if (q[Q_W-1] && !(&q[Q_W-2:ELEM_BITS-1])) begin
         return {1'b1, {(ELEM_BITS-1){1'b0}}};
      end
      return q[ELEM_BITS-1:0];
   endfunction

   // handshake
   logic [LAST:0] v_ff;
   logic [LAST:0] v_in;
   logic [LAST:0] ready;
   logic          req_acc;
   logic          rsp_acc;

   // payload pipeline
   logic signed [ELEM_BITS-1:0] elem_ff [0:LAST-1][0:3];
   axrot_pkg::axis_type         axis_ff [0:LAST-1];
   axrot_pkg::quad_type         quad_ff [0:6];
   logic [T_W-1:0]              t_ff    [0:5][0:1];
   logic [T_W-1:0]              t2_ff   [1:4][0:1];
   logic [T_W-1:0]              h_ff    [2:5][0:1];
   logic [T_W-1:0]              sn_ff   [0:1];
   logic signed [axrot_pkg::TRIG_W-1:0] sin_ff;
   logic signed [axrot_pkg::TRIG_W-1:0] cos_ff;
   logic signed [ELEM_BITS-1:0] u_ff;
   logic signed [ELEM_BITS-1:0] w_ff;
   logic signed [PROD_W-1:0]    prod_ff [0:3];
   logic signed [ELEM_BITS-1:0] res_ff  [0:3];

   // next values
   logic [ANGLE_BITS+15:0]          ang_ext;
   logic [axrot_pkg::PHASE_W-1:0]   phase;
   logic [axrot_pkg::X_W-1:0]       x_lo;
   logic [axrot_pkg::XC_W-1:0]      x_co;
   logic [T_W-1:0]                  t_in    [0:1];
   logic [T_W-1:0]                  t2_in   [0:1];
   logic [T_W-1:0]                  h2_in   [0:1];
   logic [T_W-1:0]                  h3_in   [0:1];
   logic [T_W-1:0]                  h4_in   [0:1];
   logic [T_W-1:0]                  h5_in   [0:1];
   logic [T_W-1:0]                  sn_in   [0:1];
   logic [axrot_pkg::SN_W-1:0]      rnd     [0:1];
   logic [axrot_pkg::TRIG_W-1:0]    mag_raw [0:1];
   logic signed [axrot_pkg::TRIG_W-1:0] mag [0:1];
   logic signed [axrot_pkg::TRIG_W-1:0] sin_in;
   logic signed [axrot_pkg::TRIG_W-1:0] cos_in;
   logic signed [ELEM_BITS-1:0]     u_in;
   logic signed [ELEM_BITS-1:0]     w_in;
   logic signed [PROD_W-1:0]        prod_in [0:3];
   logic signed [ELEM_BITS-1:0]     rot_p;
   logic signed [ELEM_BITS-1:0]     rot_q;
   logic signed [ELEM_BITS-1:0]     res_in  [0:3];

   // a stage takes new data when empty or when its successor moves
   always_comb begin
      ready[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         ready[i] = !v_ff[i] || ready[i+1];
      end
      v_in = {v_ff[LAST-1:0], req_valid};
   end

   assign req_stall = !ready[0];
   assign rsp_valid = v_ff[LAST];
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i <= LAST; i++) begin
            if (ready[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // stage 0: phase and quarter-wave arguments
   always_comb begin
      ang_ext  = {req_angle, 16'b0};
      phase    = ang_ext[ANGLE_BITS+15 -: axrot_pkg::PHASE_W];
      x_lo     = phase[axrot_pkg::X_W-1:0];
      x_co     = axrot_pkg::QUARTER - axrot_pkg::XC_W'(x_lo);
      t_in[0]  = {1'b0, x_lo, 16'b0};
      t_in[1]  = {x_co, 16'b0};
   end

   // stages 1..6: Horner evaluation, one multiply per stage per lane
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         t2_in[l] = axrot_pkg::mul_q30(t_ff[0][l], t_ff[0][l]);
         h2_in[l] = axrot_pkg::C7 - axrot_pkg::mul_q30(t2_ff[1][l], axrot_pkg::C9);
         h3_in[l] = axrot_pkg::C5 - axrot_pkg::mul_q30(t2_ff[2][l], h_ff[2][l]);
         h4_in[l] = axrot_pkg::C3 - axrot_pkg::mul_q30(t2_ff[3][l], h_ff[3][l]);
         h5_in[l] = axrot_pkg::C1 - axrot_pkg::mul_q30(t2_ff[4][l], h_ff[4][l]);
         sn_in[l] = axrot_pkg::mul_q30(t_ff[5][l], h_ff[5][l]);
      end
   end

   // stage 7: Q30 to Q15, clamp, quadrant fold, operand select
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rnd[l]     = axrot_pkg::SN_W'(sn_ff[l]) + axrot_pkg::SINE_HALF;
         mag_raw[l] = rnd[l][axrot_pkg::SN_W-1:axrot_pkg::FRAC_BITS];
         mag[l]     = (mag_raw[l] > axrot_pkg::SINE_ONE) ?
                      $signed(axrot_pkg::SINE_ONE) : $signed(mag_raw[l]);
      end
      unique case (quad_ff[6])
         axrot_pkg::QUAD_0: begin
            sin_in = mag[0];
            cos_in = mag[1];
         end
         axrot_pkg::QUAD_1: begin
            sin_in = mag[1];
            cos_in = -mag[0];
         end
         axrot_pkg::QUAD_2: begin
            sin_in = -mag[0];
            cos_in = -mag[1];
         end
         axrot_pkg::QUAD_3: begin
            sin_in = -mag[1];
            cos_in = mag[0];
         end
      endcase
      // each of X, Y, Z reduces to p = u*c - w*s, q = u*s + w*c; AXIS_NONE keeps its elements
      unique case (axis_ff[6])
         axrot_pkg::AXIS_X: begin
            u_in = elem_ff[6][1];
            w_in = elem_ff[6][2];
         end
         axrot_pkg::AXIS_Y: begin
            u_in = elem_ff[6][2];
            w_in = elem_ff[6][0];
         end
         axrot_pkg::AXIS_Z: begin
            u_in = elem_ff[6][0];
            w_in = elem_ff[6][1];
         end
         axrot_pkg::AXIS_NONE: begin
            u_in = elem_ff[6][0];
            w_in = elem_ff[6][1];
         end
      endcase
   end

   // stage 8: products
   always_comb begin
      prod_in[0] = PROD_W'(u_ff) * PROD_W'(cos_ff);
      prod_in[1] = PROD_W'(w_ff) * PROD_W'(sin_ff);
      prod_in[2] = PROD_W'(u_ff) * PROD_W'(sin_ff);
      prod_in[3] = PROD_W'(w_ff) * PROD_W'(cos_ff);
   end

   // stage 9: sum, round, saturate, place
   always_comb begin
      rot_p = round_sat(SUM_W'(prod_ff[0]) - SUM_W'(prod_ff[1]));
      rot_q = round_sat(SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]));
      for (int k = 0; k < 4; k++) begin
         res_in[k] = elem_ff[LAST-1][k];
      end
      unique case (axis_ff[LAST-1])
         axrot_pkg::AXIS_X: begin
            res_in[1] = rot_p;
            res_in[2] = rot_q;
         end
         axrot_pkg::AXIS_Y: begin
            res_in[2] = rot_p;
            res_in[0] = rot_q;
         end
         axrot_pkg::AXIS_Z: begin
            res_in[0] = rot_p;
            res_in[1] = rot_q;
         end
         axrot_pkg::AXIS_NONE: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         elem_ff[0][0] <= req_elem0;
         elem_ff[0][1] <= req_elem1;
         elem_ff[0][2] <= req_elem2;
         elem_ff[0][3] <= req_elem3;
         axis_ff[0]    <= axrot_pkg::axis_type'(req_axis);
         quad_ff[0]    <= axrot_pkg::quad_type'(phase[axrot_pkg::PHASE_W-1 -: 2]);
         t_ff[0]       <= t_in;
      end
      for (int i = 1; i < LAST; i++) begin
         if (ready[i]) begin
            elem_ff[i] <= elem_ff[i-1];
            axis_ff[i] <= axis_ff[i-1];
         end
      end
      for (int i = 1; i <= 6; i++) begin
         if (ready[i]) begin
            quad_ff[i] <= quad_ff[i-1];
         end
      end
      for (int i = 1; i <= 5; i++) begin
         if (ready[i]) begin
            t_ff[i] <= t_ff[i-1];
         end
      end
      if (ready[1]) begin
         t2_ff[1] <= t2_in;
      end
      for (int i = 2; i <= 4; i++) begin
         if (ready[i]) begin
            t2_ff[i] <= t2_ff[i-1];
         end
      end
      if (ready[2]) begin
         h_ff[2] <= h2_in;
      end
      if (ready[3]) begin
         h_ff[3] <= h3_in;
      end
      if (ready[4]) begin
         h_ff[4] <= h4_in;
      end
      if (ready[5]) begin
         h_ff[5] <= h5_in;
      end
      if (ready[6]) begin
         sn_ff <= sn_in;
      end
      if (ready[7]) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
         u_ff   <= u_in;
         w_ff   <= w_in;
      end
      if (ready[8]) begin
         prod_ff <= prod_in;
      end
      if (ready[LAST]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_res0 = res_ff[0];
   assign rsp_res1 = res_ff[1];
   assign rsp_res2 = res_ff[2];
   assign rsp_res3 = res_ff[3];

   // backpressure at the input only when every stage is full and output stalls
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && (&v_ff)))
      else $error("input stalled with a bubble in the pipeline");

   // occupancy changes exactly by transactions in and out
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(v_ff) ==
                $past($countones(v_ff)) + int'($past(req_acc)) - int'($past(rsp_acc))))
      else $error("transaction lost or duplicated in the pipeline");

   // sine and cosine of one angle are never both zero
   a_trig_nonzero: assert property (@(posedge clock) disable iff (reset)
      v_ff[7] |-> (sin_ff != '0 || cos_ff != '0))
      else $error("sine and cosine both zero");

endmodule

`default_nettype wire
